[hw/rtl/lssp_pkg.sv]
package lssp_pkg;

	// Field and state widths.
	localparam int SENSOR_W    = 8;
	localparam int BASE_W      = 7;
	localparam int GAIN_W      = 16;
	localparam int ERR_W       = 5;
	localparam int DIFF_W      = ERR_W + 1;
	localparam int SUM_BITS    = 24;
	localparam int CORR_W      = 16;
	localparam int TGT_W       = 8;
	localparam int TARGET_LIMIT = 100;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GAIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 2'd3;

	localparam logic [BASE_W-1:0] BASE_RESET = 7'd50;

	// Product and accumulator widths.
	localparam int PROD_P_W   = GAIN_W + ERR_W;
	localparam int PROD_I_W   = GAIN_W + SUM_BITS;
	localparam int PROD_D_W   = GAIN_W + DIFF_W;
	localparam int ACC_W      = PROD_I_W + 2;
	localparam int FRAC_SHIFT = 9;
	localparam int ROUND_BIAS = (1 << FRAC_SHIFT) - 1;
	localparam int QUOT_W     = ACC_W - FRAC_SHIFT;
	localparam int CORR_MAX   = (1 << (CORR_W - 1)) - 1;
	localparam int CORR_MIN   = -CORR_MAX - 1;
	localparam int SPEED_W    = CORR_W + 2;

	// Special sensor patterns.
	localparam logic [SENSOR_W-1:0] PAT_ALL_DARK  = 8'hFF;
	localparam logic [SENSOR_W-1:0] PAT_ALL_CLEAR = 8'h00;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
	} gain_set_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]    err;
		logic signed [DIFF_W-1:0]   diff;
		logic signed [SUM_BITS-1:0] sum;
	} err_word_t;

	typedef struct packed {
		logic signed [PROD_P_W-1:0] prod_p;
		logic signed [PROD_I_W-1:0] prod_i;
		logic signed [PROD_D_W-1:0] prod_d;
	} prod_word_t;

	// Sensor pattern to position error in half units.
	function automatic logic signed [ERR_W-1:0] pattern_error(
		input logic [SENSOR_W-1:0]  bits,
		input logic signed [ERR_W-1:0] last_err
	);
		logic signed [ERR_W-1:0] e;
		case (bits)
			8'h80: e = -5'sd8;
			8'h40: e = -5'sd6;
			8'h20: e = -5'sd4;
			8'h10: e = -5'sd2;
			8'h08: e = 5'sd2;
			8'h04: e = 5'sd4;
			8'h02: e = 5'sd6;
			8'h01: e = 5'sd8;
			8'hC0: e = -5'sd7;
			8'h60: e = -5'sd5;
			8'h30: e = -5'sd3;
			8'h18: e = 5'sd0;
			8'h0C: e = 5'sd3;
			8'h06: e = 5'sd5;
			8'h03: e = 5'sd7;
			8'hE0: e = -5'sd6;
			8'h70: e = -5'sd2;
			8'h38: e = 5'sd0;
			8'h1C: e = 5'sd2;
			8'h0E: e = 5'sd6;
			PAT_ALL_DARK: e = 5'sd0;
			PAT_ALL_CLEAR: e = last_err;
			default: e = 5'sd0;
		endcase
		return e;
	endfunction

	// Clamp a wheel speed to the target limit and keep its low bits.
	function automatic logic [TGT_W-1:0] clamp_target(input logic signed [SPEED_W-1:0] v);
		logic signed [SPEED_W-1:0] lim;
		logic signed [SPEED_W-1:0] r;
		lim = SPEED_W'(TARGET_LIMIT);
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return r[TGT_W-1:0];
	endfunction

endpackage

[hw/rtl/lssp_error.sv]
module lssp_error (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lssp_pkg::SENSOR_W-1:0]       sensor_bits,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lssp_pkg::err_word_t                 out_word
);

	localparam int SW = lssp_pkg::SUM_BITS;

	logic                                  valid_s1;
	lssp_pkg::err_word_t                   word_s1;
	logic signed [lssp_pkg::ERR_W-1:0]     last_err_q;
	logic signed [SW-1:0]                  err_sum_q;

	logic signed [lssp_pkg::ERR_W-1:0]     err;
	logic signed [lssp_pkg::DIFF_W-1:0]    diff;
	logic signed [SW:0]                    sum_wide;
	logic signed [SW-1:0]                  sum_next;
	logic                                  accept;

	// Table lookup, difference and saturating integral.
	always_comb begin
		err = lssp_pkg::pattern_error(sensor_bits, last_err_q);
		diff = lssp_pkg::DIFF_W'(err) - lssp_pkg::DIFF_W'(last_err_q);
		sum_wide = (SW + 1)'(err_sum_q) + (SW + 1)'(err);
		if (sum_wide[SW] != sum_wide[SW-1]) begin
			sum_next = sum_wide[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
		end else begin
			sum_next = sum_wide[SW-1:0];
		end
	end

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// Stage valid and the running controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			last_err_q <= '0;
			err_sum_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				last_err_q <= err;
				err_sum_q  <= sum_next;
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.err  <= err;
			word_s1.diff <= diff;
			word_s1.sum  <= sum_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

[hw/rtl/lssp_product.sv]
module lssp_product (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lssp_pkg::gain_set_t   gains,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lssp_pkg::err_word_t   in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lssp_pkg::prod_word_t  out_word
);

	localparam int PW = lssp_pkg::PROD_P_W;
	localparam int IW = lssp_pkg::PROD_I_W;
	localparam int DW = lssp_pkg::PROD_D_W;

	logic                  valid_s2;
	lssp_pkg::prod_word_t  word_s2;
	logic signed [PW-1:0]  prod_p;
	logic signed [IW-1:0]  prod_i;
	logic signed [DW-1:0]  prod_d;
	logic                  accept;

	// Three independent multiplies of the gains by error, sum and difference.
	assign prod_p = PW'(gains.gain_p) * PW'(in_word.err);
	assign prod_i = IW'(gains.gain_i) * IW'(in_word.sum);
	assign prod_d = DW'(gains.gain_d) * DW'(in_word.diff);

	assign in_ready = !valid_s2 || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s2.prod_p <= prod_p;
			word_s2.prod_i <= prod_i;
			word_s2.prod_d <= prod_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

[hw/rtl/lssp_output.sv]
module lssp_output (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [lssp_pkg::BASE_W-1:0]             base_speed,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  lssp_pkg::prod_word_t                    in_word,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [lssp_pkg::TGT_W-1:0]              right_target,
	output logic [lssp_pkg::TGT_W-1:0]              left_target,
	output logic signed [lssp_pkg::CORR_W-1:0]      steer_correction
);

	localparam int AW = lssp_pkg::ACC_W;
	localparam int QW = lssp_pkg::QUOT_W;
	localparam int CW = lssp_pkg::CORR_W;
	localparam int SPW = lssp_pkg::SPEED_W;

	logic                         valid_s3;
	logic signed [CW-1:0]         corr_s3;
	logic                         valid_q;
	logic [lssp_pkg::TGT_W-1:0]   right_q;
	logic [lssp_pkg::TGT_W-1:0]   left_q;
	logic signed [CW-1:0]         corr_q;

	logic signed [AW-1:0]         acc;
	logic signed [AW-1:0]         bias;
	logic signed [AW-1:0]         rounded;
	logic signed [QW-1:0]         quot;
	logic signed [CW-1:0]         corr_sat;
	logic signed [SPW-1:0]        base_ext;
	logic signed [SPW-1:0]        right_sum;
	logic signed [SPW-1:0]        left_sum;
	logic                         ready_s3;
	logic                         accept_s3;
	logic                         accept_q;

	// Sum the terms, divide by 512 toward zero and saturate to 16 bits.
	always_comb begin
		acc = AW'(in_word.prod_p) + AW'(in_word.prod_i) + AW'(in_word.prod_d);
		bias = acc[AW-1] ? AW'(lssp_pkg::ROUND_BIAS) : '0;
		rounded = acc + bias;
		quot = rounded[AW-1:lssp_pkg::FRAC_SHIFT];
		if (quot > QW'(lssp_pkg::CORR_MAX)) begin
			corr_sat = CW'(lssp_pkg::CORR_MAX);
		end else if (quot < QW'(lssp_pkg::CORR_MIN)) begin
			corr_sat = CW'(lssp_pkg::CORR_MIN);
		end else begin
			corr_sat = quot[CW-1:0];
		end
	end

	// Wheel speeds from the registered correction.
	always_comb begin
		base_ext  = signed'(SPW'(base_speed));
		right_sum = base_ext + SPW'(corr_s3);
		left_sum  = base_ext - SPW'(corr_s3);
	end

	assign ready_s3  = !valid_q || out_ready;
	assign in_ready  = !valid_s3 || ready_s3;
	assign accept_s3 = in_valid && in_ready;
	assign accept_q  = valid_s3 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s3) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_s3) begin
			corr_s3 <= corr_sat;
		end
		if (accept_q) begin
			right_q <= lssp_pkg::clamp_target(right_sum);
			left_q  <= lssp_pkg::clamp_target(left_sum);
			corr_q  <= corr_s3;
		end
	end

	assign out_valid        = valid_q;
	assign right_target     = right_q;
	assign left_target      = left_q;
	assign steer_correction = corr_q;

endmodule

[hw/rtl/line_sensor_steering_pid.sv]
// Channel   Direction  Word
// s_axis    in         tdata[7:0] sensor_bits
// m_axis    out        tdata[7:0] right_target, [15:8] left_target, [31:16] steer_correction
// wr_*      in         register write: 0 base_speed, 1 gain_p, 2 gain_i, 3 gain_d
//
// One word is taken every cycle unless all stages are full and the output is stalled.
// The four stages are error lookup with integral update, the three gain multiplies,
// the scaled and saturated correction, and the clamped wheel targets.
// Reset clears the integral, the last error and all stage valids; base_speed returns to 50
// and the gains to zero.
// A stalled output holds its word; stages behind it keep filling until all four are full.
module line_sensor_steering_pid (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,   // [7:0] sensor_bits
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [7:0] right_target, [15:8] left_target, [31:16] steer_correction
	output logic [31:0]                          m_axis_tdata,
	input  logic                                 wr_en,
	input  logic [lssp_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [lssp_pkg::CFG_DATA_W-1:0]      wr_data
);

	logic [lssp_pkg::BASE_W-1:0]            base_speed_q;
	lssp_pkg::gain_set_t                    gains_q;

	logic                                   err_valid;
	logic                                   err_ready;
	lssp_pkg::err_word_t                    err_word;
	logic                                   prod_valid;
	logic                                   prod_ready;
	lssp_pkg::prod_word_t                   prod_word;
	logic [lssp_pkg::TGT_W-1:0]             right_target;
	logic [lssp_pkg::TGT_W-1:0]             left_target;
	logic signed [lssp_pkg::CORR_W-1:0]     steer_correction;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q <= lssp_pkg::BASE_RESET;
			gains_q      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				lssp_pkg::REG_BASE_SPEED: base_speed_q <= wr_data[lssp_pkg::BASE_W-1:0];
				lssp_pkg::REG_GAIN_P: gains_q.gain_p <= signed'(wr_data);
				lssp_pkg::REG_GAIN_I: gains_q.gain_i <= signed'(wr_data);
				lssp_pkg::REG_GAIN_D: gains_q.gain_d <= signed'(wr_data);
				default: base_speed_q <= base_speed_q;
			endcase
		end
	end

	lssp_error u_error (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.sensor_bits (s_axis_tdata),
		.out_valid   (err_valid),
		.out_ready   (err_ready),
		.out_word    (err_word)
	);

	lssp_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.in_valid  (err_valid),
		.in_ready  (err_ready),
		.in_word   (err_word),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_word  (prod_word)
	);

	lssp_output u_output (
		.clk              (clk),
		.arst_n           (arst_n),
		.base_speed       (base_speed_q),
		.in_valid         (prod_valid),
		.in_ready         (prod_ready),
		.in_word          (prod_word),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.right_target     (right_target),
		.left_target      (left_target),
		.steer_correction (steer_correction)
	);

	assign m_axis_tdata = {steer_correction, left_target, right_target};

	// Input backpressure only when every stage is full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while the pipeline has room");

	// With no correction both wheels get the same clamped base speed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[31:16] == 16'h0000))
			|-> (m_axis_tdata[7:0] == m_axis_tdata[15:8]))
		else $error("wheel targets differ with zero correction");

endmodule
